@@ sv/ufdb_pkg.sv @@
package ufdb_pkg;

  // Receive buffer depth default and fixed field widths.
  localparam int RxDepthDefault = 32;
  localparam int WposW          = 6;
  localparam int HeadLen        = 5;
  localparam int RunW           = 3;

  // Frame recognition constants.
  localparam logic [7:0]      FramePassLen = 8'd24;
  localparam logic [7:0]      PassMark     = 8'h52;
  localparam logic [7:0]      TypeTouch    = 8'h65;
  localparam logic [7:0]      TypePage     = 8'h66;
  localparam logic [7:0]      TypeData     = 8'h71;
  localparam logic [7:0]      TypeReady    = 8'h88;
  localparam logic [RunW-1:0] RunMax       = 3'd7;

  // Configuration register indexes.
  localparam logic [1:0] CfgEndByte     = 2'd0;
  localparam logic [1:0] CfgEndRunLen   = 2'd1;
  localparam logic [1:0] CfgWdogReload  = 2'd2;
  localparam logic [1:0] CfgDataEnable  = 2'd3;

  typedef enum logic [1:0] {
    ModeDisplay = 2'd0,
    ModeService = 2'd1,
    ModeTick    = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    KindFwdService  = 3'd0,
    KindFwdDisplay  = 3'd1,
    KindTouch       = 3'd2,
    KindPage        = 3'd3,
    KindData        = 3'd4,
    KindReady       = 3'd5,
    KindPassthrough = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    OwnerFree    = 2'd0,
    OwnerDisplay = 2'd1,
    OwnerService = 2'd2
  } owner_e;

  typedef struct packed {
    logic [7:0]      end_byte;
    logic [RunW-1:0] end_run_length;
    logic [7:0]      watchdog_reload;
    logic            data_report_enable;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  out_byte;
    logic [7:0]  key_status;
    logic [31:0] data_word;
  } result_t;

  typedef struct packed {
    logic   passthrough;
    owner_e owner;
  } status_t;

endpackage

@@ sv/ufdb_cfg_regs.sv @@
module ufdb_cfg_regs
  import ufdb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgEndByte:    cfg_d.end_byte           = cfg_wdata_i;
        CfgEndRunLen:  cfg_d.end_run_length     = cfg_wdata_i[RunW-1:0];
        CfgWdogReload: cfg_d.watchdog_reload    = cfg_wdata_i;
        CfgDataEnable: cfg_d.data_report_enable = cfg_wdata_i[0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.end_byte           <= 8'hFF;
      cfg_q.end_run_length     <= 3'd3;
      cfg_q.watchdog_reload    <= 8'd8;
      cfg_q.data_report_enable <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/ufdb_core.sv @@
module ufdb_core
  import ufdb_pkg::*;
#(
  parameter int RX_DEPTH = RxDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [1:0] mode_i,
  input  logic [7:0] rx_byte_i,
  input  cfg_t       cfg_i,
  output logic       res_valid_o,
  output result_t    res_o,
  output status_t    status_o
);

  logic                 pass_q, pass_d;
  owner_e               owner_q, owner_d;
  logic [WposW-1:0]     wpos_q, wpos_d;
  logic [RunW-1:0]      run_q, run_d;
  logic [7:0]           wdog_q, wdog_d;
  logic [HeadLen-1:0][7:0] head_q, head_d;

  logic                 take;
  logic [WposW-1:0]     wp_base;
  logic [WposW-1:0]     wp_next;
  logic                 wp_room;
  logic [RunW-1:0]      run_len;
  logic [RunW-1:0]      run_new;
  logic                 close;
  logic [7:0]           frame_size;

  always_comb begin
    pass_d      = pass_q;
    owner_d     = owner_q;
    wpos_d      = wpos_q;
    run_d       = run_q;
    wdog_d      = wdog_q;
    head_d      = head_q;
    take        = 1'b0;
    wp_base     = wpos_q;
    wp_next     = wpos_q;
    wp_room     = 1'b0;
    run_new     = run_q;
    close       = 1'b0;
    frame_size  = '0;
    res_valid_o = 1'b0;
    res_o       = '{kind: KindFwdService, out_byte: 8'd0, key_status: 8'd0,
                    data_word: 32'd0};
    run_len     = (cfg_i.end_run_length == '0) ? RunW'(1) : cfg_i.end_run_length;

    case (mode_i)
      ModeTick: begin
        if (pass_q) begin
          if (wdog_q == 8'd0) begin
            pass_d = 1'b0;
          end else begin
            wdog_d = wdog_q - 8'd1;
          end
        end
      end
      ModeDisplay: begin
        if (pass_q) begin
          res_valid_o    = 1'b1;
          res_o.kind     = KindFwdService;
          res_o.out_byte = rx_byte_i;
        end else if (owner_q != OwnerService) begin
          owner_d = OwnerDisplay;
          take    = 1'b1;
        end
      end
      ModeService: begin
        if (pass_q) begin
          wdog_d         = cfg_i.watchdog_reload;
          res_valid_o    = 1'b1;
          res_o.kind     = KindFwdDisplay;
          res_o.out_byte = rx_byte_i;
        end else begin
          // A takeover by the service port restarts the buffer.
          if (owner_q != OwnerService) begin
            owner_d = OwnerService;
            wp_base = '0;
          end
          take = 1'b1;
        end
      end
      default: ;
    endcase

    if (take) begin
      wp_room = (wp_base < WposW'(RX_DEPTH));
      wp_next = wp_room ? wp_base + WposW'(1) : wp_base;
      for (int i = 0; i < HeadLen; i++) begin
        if (wp_room && wp_base == WposW'(i)) begin
          head_d[i] = rx_byte_i;
        end
      end
      wpos_d = wp_next;

      if (rx_byte_i == cfg_i.end_byte) begin
        run_new = (run_q == RunMax) ? RunMax : run_q + RunW'(1);
      end else begin
        run_new = '0;
      end
      run_d = run_new;

      // A frame closes only on the byte that brings the run up to length.
      close = (run_new != run_q) && (run_new == run_len);
      if (close) begin
        owner_d    = OwnerFree;
        wpos_d     = '0;
        frame_size = {{(8-WposW){1'b0}}, wp_next} - {{(8-RunW){1'b0}}, run_len};
        if (frame_size == FramePassLen && head_d[1] == PassMark) begin
          pass_d      = 1'b1;
          wdog_d      = cfg_i.watchdog_reload;
          res_valid_o = 1'b1;
          res_o.kind  = KindPassthrough;
        end else begin
          case (head_d[0])
            TypeTouch: begin
              res_valid_o      = 1'b1;
              res_o.kind       = KindTouch;
              res_o.out_byte   = head_d[2];
              res_o.key_status = head_d[3];
            end
            TypePage: begin
              res_valid_o    = 1'b1;
              res_o.kind     = KindPage;
              res_o.out_byte = head_d[1];
            end
            TypeData: begin
              if (cfg_i.data_report_enable) begin
                res_valid_o     = 1'b1;
                res_o.kind      = KindData;
                res_o.data_word = {head_d[4], head_d[3], head_d[2], head_d[1]};
              end
            end
            TypeReady: begin
              res_valid_o     = 1'b1;
              res_o.kind      = KindReady;
              res_o.data_word = {16'd0, head_d[2], head_d[1]};
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q  <= 1'b0;
      owner_q <= OwnerFree;
      wpos_q  <= '0;
      run_q   <= '0;
      wdog_q  <= '0;
      head_q  <= '0;
    end else if (fire_i) begin
      pass_q  <= pass_d;
      owner_q <= owner_d;
      wpos_q  <= wpos_d;
      run_q   <= run_d;
      wdog_q  <= wdog_d;
      head_q  <= head_d;
    end
  end

  assign status_o = '{passthrough: pass_q, owner: owner_q};

endmodule

@@ sv/uart_frame_deframer_bridge.sv @@
// Serial frame receiver and passthrough bridge. Each transaction on the input
// channel is a display byte, a service byte or a watchdog tick; each produces
// at most one result transaction (forwarded byte, touch, page id, data, ready
// or passthrough entered). The block accepts one transaction per clock cycle
// while in_stall_o is low. An accepted input is held in the input register,
// and its result is captured in the result register, which drives the
// outputs. All frame and state logic sits in the single stage between the
// two registers. A held result stalls the input only once the input register
// is also full.
// Configuration registers are written through cfg_we_i, cfg_idx_i and
// cfg_wdata_i and should be changed only while the block is idle.
module uart_frame_deframer_bridge
  import ufdb_pkg::*;
#(
  parameter int RX_DEPTH = RxDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  out_byte_o,
  output logic [7:0]  key_status_o,
  output logic [31:0] data_word_o
);

  cfg_t       cfg;
  logic       in_valid_q;
  logic [1:0] mode_q;
  logic [7:0] rx_byte_q;
  logic       advance;
  logic       fire;
  logic       res_valid;
  result_t    res;
  status_t    status;
  logic       out_valid_q;
  result_t    out_q;

  ufdb_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      mode_q    <= mode_i;
      rx_byte_q <= rx_byte_i;
    end
  end

  ufdb_core #(
    .RX_DEPTH (RX_DEPTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .mode_i      (mode_q),
    .rx_byte_i   (rx_byte_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res),
    .status_o    (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= fire && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = out_q.kind;
  assign out_byte_o   = out_q.out_byte;
  assign key_status_o = out_q.key_status;
  assign data_word_o  = out_q.data_word;

`ifndef SYNTHESIS
  // The buffer is always released before passthrough starts.
  a_pass_owner_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.passthrough |-> status.owner == OwnerFree)
    else $error("buffer owned while in passthrough");

  // A passthrough entered report must leave the block in passthrough.
  a_pass_entered : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && res_valid && res.kind == KindPassthrough) |=> status.passthrough)
    else $error("passthrough report without passthrough state");

  // Bytes are forwarded only while in passthrough.
  a_fwd_in_pass : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && res_valid && (res.kind == KindFwdService || res.kind == KindFwdDisplay))
      |-> status.passthrough)
    else $error("byte forwarded outside passthrough");
`endif

endmodule

@@ test/ufdb_result_checker.sv @@
`timescale 1ns / 100ps
module ufdb_result_checker
  import ufdb_pkg::*;
#(
  parameter int RX_DEPTH = RxDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  out_byte_i,
  input  logic [7:0]  key_status_i,
  input  logic [31:0] data_word_i,
  output int          pending_o,
  output int          fail_count_o
);

  cfg_t             cfg;
  logic             pass_mode;
  owner_e           owner;
  logic [WposW-1:0] wr_pos;
  logic [RunW-1:0]  run_cnt;
  logic [7:0]       wdog_cnt;
  logic [7:0]       head [HeadLen];
  result_t          expected_reports [$];
  int               mismatches;

  function automatic result_t report(kind_e k, logic [7:0] b, logic [7:0] ks,
                                     logic [31:0] w);
    report = '{kind: k, out_byte: b, key_status: ks, data_word: w};
  endfunction

  function automatic int field_check(string name, logic [31:0] expd, logic [31:0] act);
    if (expd !== act) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, expd, act);
      return 1;
    end
    return 0;
  endfunction

  // One byte into the receive buffer, with end-run tracking and frame decode.
  task automatic store_byte(input logic [7:0] b);
    logic [RunW-1:0] eff_len;
    logic [RunW-1:0] prev_run;
    logic [7:0]      frame_size;
    eff_len = (cfg.end_run_length == 3'd0) ? 3'd1 : cfg.end_run_length;
    if (int'(wr_pos) < RX_DEPTH) begin
      if (int'(wr_pos) < HeadLen) head[wr_pos] = b;
      wr_pos = wr_pos + 1'b1;
    end
    prev_run = run_cnt;
    if (b == cfg.end_byte) begin
      if (run_cnt < RunMax) run_cnt = run_cnt + 1'b1;
    end else begin
      run_cnt = '0;
    end
    // A frame closes only on the byte that brings the run up to the length.
    if (run_cnt != prev_run && run_cnt == eff_len) begin
      frame_size = 8'(wr_pos) - 8'(eff_len);
      owner = OwnerFree;
      wr_pos = '0;
      if (frame_size == FramePassLen && head[1] == PassMark) begin
        pass_mode = 1'b1;
        wdog_cnt = cfg.watchdog_reload;
        expected_reports.push_back(report(KindPassthrough, 8'h00, 8'h00, 32'h0));
      end else begin
        case (head[0])
          TypeTouch: expected_reports.push_back(report(KindTouch, head[2], head[3], 32'h0));
          TypePage:  expected_reports.push_back(report(KindPage, head[1], 8'h00, 32'h0));
          TypeData: begin
            if (cfg.data_report_enable) begin
              expected_reports.push_back(report(KindData, 8'h00, 8'h00,
                                                {head[4], head[3], head[2], head[1]}));
            end
          end
          TypeReady: begin
            expected_reports.push_back(report(KindReady, 8'h00, 8'h00,
                                              {16'h0, head[2], head[1]}));
          end
          default: ;
        endcase
      end
    end
  endtask

  task automatic bridge_step(input logic [1:0] mode, input logic [7:0] b);
    case (mode)
      ModeTick: begin
        if (pass_mode) begin
          if (wdog_cnt == 8'd0) pass_mode = 1'b0;
          else wdog_cnt = wdog_cnt - 1'b1;
        end
      end
      ModeDisplay: begin
        if (pass_mode) begin
          expected_reports.push_back(report(KindFwdService, b, 8'h00, 32'h0));
        end else if (owner != OwnerService) begin
          owner = OwnerDisplay;
          store_byte(b);
        end
      end
      ModeService: begin
        if (pass_mode) begin
          wdog_cnt = cfg.watchdog_reload;
          expected_reports.push_back(report(KindFwdDisplay, b, 8'h00, 32'h0));
        end else begin
          // The service port takes the buffer over and restarts it.
          if (owner != OwnerService) begin
            owner = OwnerService;
            wr_pos = '0;
          end
          store_byte(b);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    if (!rst_ni) begin
      cfg = '{end_byte: 8'hFF, end_run_length: 3'd3, watchdog_reload: 8'd8,
              data_report_enable: 1'b1};
      pass_mode = 1'b0;
      owner = OwnerFree;
      wr_pos = '0;
      run_cnt = '0;
      wdog_cnt = 8'd0;
      foreach (head[i]) head[i] = 8'h00;
      expected_reports.delete();
      mismatches = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_reports.size() == 0) begin
          $error("unexpected result transaction: kind %0d out_byte 'h%0h", kind_i,
                 out_byte_i);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          mismatches += field_check("kind", 32'(want.kind), 32'(kind_i))
                      + field_check("out_byte", 32'(want.out_byte), 32'(out_byte_i))
                      + field_check("key_status", 32'(want.key_status), 32'(key_status_i))
                      + field_check("data_word", want.data_word, data_word_i);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgEndByte:    cfg.end_byte = cfg_wdata_i;
          CfgEndRunLen:  cfg.end_run_length = cfg_wdata_i[RunW-1:0];
          CfgWdogReload: cfg.watchdog_reload = cfg_wdata_i;
          CfgDataEnable: cfg.data_report_enable = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) bridge_step(mode_i, rx_byte_i);
      pending_o <= expected_reports.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

@@ test/tb_uart_frame_deframer_bridge.sv @@
`timescale 1ns / 100ps
module tb_uart_frame_deframer_bridge;
  import ufdb_pkg::*;

  localparam int         ItemTarget = 1750;
  localparam int         PhaseItems = 250;
  localparam logic [1:0] ModeUnused = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [7:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  mode_i;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  kind_o;
  logic [7:0]  out_byte_o;
  logic [7:0]  key_status_o;
  logic [31:0] data_word_o;

  int         pending;
  int         fail_count;
  int         stall_left;
  int         items_sent;
  logic       idle_en;
  cfg_t       cur_cfg;
  logic [7:0] frame_types [4] = '{TypeTouch, TypePage, TypeData, TypeReady};

  uart_frame_deframer_bridge dut (.*);

  ufdb_result_checker u_results (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .mode_i       (mode_i),
    .rx_byte_i    (rx_byte_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_i       (kind_o),
    .out_byte_i   (out_byte_o),
    .key_status_i (key_status_o),
    .data_word_i  (data_word_o),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  // Receiver back-pressure in short random bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      out_stall_i <= 1'b0;
    end else if (idle_en && $urandom_range(0, 6) == 0) begin
      stall_left <= $urandom_range(1, 5);
      out_stall_i <= 1'b1;
    end
  end

  task automatic send(input logic [1:0] m, input logic [7:0] b);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= m;
    rx_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  function automatic int run_len();
    return (cur_cfg.end_run_length == 3'd0) ? 1 : int'(cur_cfg.end_run_length);
  endfunction

  // Frame content rarely hits the end byte, so most frames close where intended.
  function automatic logic [7:0] payload_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == cur_cfg.end_byte && $urandom_range(0, 7) != 0) b = b ^ 8'h01;
    return b;
  endfunction

  task automatic send_frame(input logic [1:0] port, input int size, input logic [7:0] b0,
                            input logic [7:0] b1, input int extra_run);
    for (int i = 0; i < size; i++) begin
      send(port, (i == 0) ? b0 : ((i == 1) ? b1 : payload_byte()));
    end
    repeat (run_len() + extra_run) send(port, cur_cfg.end_byte);
  endtask

  // Enough ticks to leave passthrough from any watchdog value.
  task automatic watchdog_expire();
    repeat (int'(cur_cfg.watchdog_reload) + 1) send(ModeTick, 8'($urandom));
  endtask

  task automatic passthrough_session();
    repeat ($urandom_range(2, 20)) begin
      case ($urandom_range(0, 2))
        0:       send(ModeDisplay, 8'($urandom));
        1:       send(ModeService, 8'($urandom));
        default: send(ModeTick, 8'($urandom));
      endcase
    end
    watchdog_expire();
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic reconfigure(input cfg_t c);
    drain_results();
    cur_cfg = c;
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgEndByte;
    cfg_wdata_i <= c.end_byte;
    @(posedge clk_i);
    cfg_idx_i <= CfgEndRunLen;
    cfg_wdata_i <= {5'b0, c.end_run_length};
    @(posedge clk_i);
    cfg_idx_i <= CfgWdogReload;
    cfg_wdata_i <= c.watchdog_reload;
    @(posedge clk_i);
    cfg_idx_i <= CfgDataEnable;
    cfg_wdata_i <= {7'b0, c.data_report_enable};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_burst();
    logic [1:0] port;
    port = ($urandom_range(0, 2) == 0) ? ModeService : ModeDisplay;
    case ($urandom_range(0, 11))
      0: send_frame(port, $urandom_range(4, 8), TypeTouch, payload_byte(), 0);
      1: send_frame(port, $urandom_range(1, 3), TypePage, payload_byte(), 0);
      2: send_frame(port, $urandom_range(5, 7), TypeData, payload_byte(), 0);
      3: send_frame(port, $urandom_range(2, 4), TypeReady, payload_byte(), 0);
      4, 5: begin
        send_frame(port, 24, payload_byte(), PassMark, 0);
        passthrough_session();
      end
      // Odd sizes, an overfull buffer and end runs past the closing length.
      6: send_frame(port, $urandom_range(0, 40), payload_byte(), payload_byte(),
                    $urandom_range(0, 5));
      7: send_frame(port, $urandom_range(23, 25), payload_byte(),
                    $urandom_range(0, 1) ? PassMark : payload_byte(), 0);
      8: begin
        // A display frame cut off by the service port, with display bytes
        // arriving while the service port owns the buffer.
        repeat ($urandom_range(1, 6)) send(ModeDisplay, payload_byte());
        for (int i = 0; i < 5; i++) begin
          send(ModeService, (i == 0) ? frame_types[$urandom_range(0, 3)] : payload_byte());
          if ($urandom_range(0, 1)) send(ModeDisplay, payload_byte());
        end
        repeat (run_len()) send(ModeService, cur_cfg.end_byte);
      end
      default: begin
        repeat ($urandom_range(1, 12)) begin
          send(2'($urandom), $urandom_range(0, 2) ? 8'($urandom) : cur_cfg.end_byte);
        end
      end
    endcase
  endtask

  initial begin
    cfg_t c;
    int   phase_end;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgEndByte;
    cfg_wdata_i = 8'h00;
    in_valid_i = 1'b0;
    mode_i = ModeDisplay;
    rx_byte_i = 8'h00;
    items_sent = 0;
    idle_en = 1'b0;
    cur_cfg = '{8'hFF, 3'd3, 8'd8, 1'b1};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: end byte zero, zero run length (acts as one).
    reconfigure('{end_byte: 8'h00, end_run_length: 3'd0, watchdog_reload: 8'd0,
                  data_report_enable: 1'b1});
    send(ModeDisplay, TypeTouch); send(ModeDisplay, 8'h01);
    send(ModeDisplay, 8'hFF); send(ModeDisplay, 8'h80); send(ModeDisplay, 8'h00);
    send(ModeService, TypePage); send(ModeService, 8'hFF); send(ModeService, 8'h00);
    send(ModeDisplay, TypeData); send(ModeDisplay, 8'hFF); send(ModeDisplay, 8'h80);
    send(ModeDisplay, 8'h01); send(ModeDisplay, 8'hFE); send(ModeDisplay, 8'h00);
    send(ModeDisplay, TypeReady); send(ModeDisplay, 8'h34); send(ModeDisplay, 8'h00);
    send(ModeDisplay, 8'h5A); send(ModeDisplay, 8'h00);
    send(ModeTick, 8'hFF); send(ModeUnused, 8'hAA);
    send(ModeDisplay, TypePage); send(ModeService, TypeReady);
    send(ModeDisplay, 8'h77); send(ModeService, 8'h00);

    for (int phase = 0; items_sent < ItemTarget; phase++) begin
      c = '{8'($urandom), 3'($urandom), 8'($urandom_range(0, 12)), 1'($urandom)};
      case (phase)
        0:       c = '{8'hFF, 3'd7, 8'd255, 1'b0};
        1:       c = '{8'h00, 3'd1, 8'd0, 1'b1};
        2:       c = '{8'hFF, 3'd3, 8'd8, 1'b1};
        default: ;
      endcase
      watchdog_expire();
      reconfigure(c);
      phase_end = items_sent + PhaseItems;
      while (items_sent < phase_end && items_sent < ItemTarget) begin
        idle_en <= (phase % 3 != 2) && ($urandom_range(0, 3) != 0)
                   && (items_sent < ItemTarget - 150);
        random_burst();
      end
    end

    idle_en <= 1'b0;
    drain_results();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
